FILE: hw/rtl/bqe_pkg.sv
// Shared types and constants for the billboard quad expander.
package bqe_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_BASIS_X_X = 3'd0;
    localparam logic [2:0] CFG_BASIS_X_Y = 3'd1;
    localparam logic [2:0] CFG_BASIS_X_Z = 3'd2;
    localparam logic [2:0] CFG_BASIS_Y_X = 3'd3;
    localparam logic [2:0] CFG_BASIS_Y_Y = 3'd4;
    localparam logic [2:0] CFG_BASIS_Y_Z = 3'd5;

    // Reset values of the basis registers (identity camera)
    localparam logic signed [15:0] BASIS_ONE  = 16'sd32767;
    localparam logic signed [15:0] BASIS_ZERO = 16'sd0;

    // Corner codes in emission order
    localparam logic [1:0] CORNER_PP = 2'd0;   // +right +up
    localparam logic [1:0] CORNER_MP = 2'd1;   // -right +up
    localparam logic [1:0] CORNER_MM = 2'd2;   // -right -up
    localparam logic [1:0] CORNER_PM = 2'd3;   // +right -up, last of the quad

    localparam int SCALED_W = 25;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [23:0] half_size;
        logic        [31:0] colour_in;
        logic        [15:0] u_start;
        logic        [15:0] v_start;
        logic        [15:0] u_end;
        logic        [15:0] v_end;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic        [31:0] colour_out;
        logic        [15:0] tex_u;
        logic        [15:0] tex_v;
        logic        [1:0]  corner;
        logic               last;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] x_x;
        logic signed [15:0] x_y;
        logic signed [15:0] x_z;
        logic signed [15:0] y_x;
        logic signed [15:0] y_y;
        logic signed [15:0] y_z;
    } basis_t;

    // Size-scaled bases, Q.12
    typedef struct packed {
        logic signed [SCALED_W-1:0] rx;
        logic signed [SCALED_W-1:0] ry;
        logic signed [SCALED_W-1:0] rz;
        logic signed [SCALED_W-1:0] ux;
        logic signed [SCALED_W-1:0] uy;
        logic signed [SCALED_W-1:0] uz;
    } scaled_t;

endpackage

FILE: hw/rtl/bqe_scale.sv
// Scales the right and up bases by the particle size.
module bqe_scale
    import bqe_pkg::*;
(
    input  basis_t      basis,
    input  logic [23:0] half_size,
    output scaled_t     scaled
);

    // Q1.15 * Q12.12 -> Q.27, arithmetic shift by 15 floors to Q.12
    function automatic logic signed [SCALED_W-1:0] scale_one(
        logic signed [15:0] b,
        logic        [23:0] s
    );
        logic signed [24:0] s_s;
        logic signed [40:0] prod;
        s_s  = {1'b0, s};
        prod = b * s_s;
        return prod[39:15];
    endfunction

    always_comb
    begin
        scaled.rx = scale_one(basis.x_x, half_size);
        scaled.ry = scale_one(basis.x_y, half_size);
        scaled.rz = scale_one(basis.x_z, half_size);
        scaled.ux = scale_one(basis.y_x, half_size);
        scaled.uy = scale_one(basis.y_y, half_size);
        scaled.uz = scale_one(basis.y_z, half_size);
    end

endmodule

FILE: hw/rtl/bqe_vertex.sv
// Forms one quad vertex from the particle, scaled bases and corner code.
module bqe_vertex
    import bqe_pkg::*;
(
    input  particle_t  particle,
    input  scaled_t    scaled,
    input  logic [1:0] corner,
    output vertex_t    vertex
);

    logic r_pos;
    logic u_pos;

    // pos +- r +- u, saturated once to 32 bits
    function automatic logic signed [31:0] axis_sum(
        logic signed [31:0]         p,
        logic signed [SCALED_W-1:0] r,
        logic signed [SCALED_W-1:0] u,
        logic                       rp,
        logic                       up
    );
        logic signed [33:0] r_term;
        logic signed [33:0] u_term;
        logic signed [33:0] sum;
        r_term = rp ? 34'(r) : -34'(r);
        u_term = up ? 34'(u) : -34'(u);
        sum    = 34'(p) + r_term + u_term;
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
            return sum[31:0];
        else if (sum[33])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

    // Corner signs
    assign r_pos = (corner == CORNER_PP) || (corner == CORNER_PM);
    assign u_pos = (corner == CORNER_PP) || (corner == CORNER_MP);

    always_comb
    begin
        vertex.vert_x     = axis_sum(particle.pos_x, scaled.rx, scaled.ux, r_pos, u_pos);
        vertex.vert_y     = axis_sum(particle.pos_y, scaled.ry, scaled.uy, r_pos, u_pos);
        vertex.vert_z     = axis_sum(particle.pos_z, scaled.rz, scaled.uz, r_pos, u_pos);
        vertex.colour_out = particle.colour_in;
        vertex.tex_u      = r_pos ? particle.u_end : particle.u_start;
        vertex.tex_v      = u_pos ? particle.v_end : particle.v_start;
        vertex.corner     = corner;
        vertex.last       = (corner == CORNER_PM);
    end

endmodule

FILE: hw/rtl/billboard_quad_expander.sv
// Top level of the billboard quad expander: registers, handshakes, corner sequencing.
//
// Each particle beat expands into four vertex beats, emitted in corner order
// (+R+U), (-R+U), (-R-U), (+R-U), one vertex per cycle while the vertex channel
// is not stalled. The four-step corner counter sequences the corners. A particle
// passes an input register, the basis scaling multipliers into a working register,
// and the per-corner add and saturate into the output register; the next particle
// is held in the input register while the current one is still emitting. Basis
// registers are written through the configuration port, index 0 to 5; other
// indexes are ignored. Writes must only be made while the block is idle; the block
// itself does not enforce this.
module billboard_quad_expander
    import bqe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        particle_valid,
    output logic        particle_stall,
    input  particle_t   particle,
    output logic        vertex_valid,
    input  logic        vertex_stall,
    output vertex_t     vertex,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    basis_t     basis_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    particle_t  s1_reg;
    logic       s2_valid_reg;
    logic       s2_valid_next;
    particle_t  s2_reg;
    scaled_t    scaled_reg;
    scaled_t    scaled_next;
    logic [1:0] corner_reg;
    logic [1:0] corner_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    vertex_t    out_reg;
    vertex_t    vertex_next;

    logic out_free;
    logic issue;
    logic s2_free;
    logic move;
    logic accept;

    assign cfg_ready = 1'b1;

    // Basis registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg.x_x <= BASIS_ONE;
            basis_reg.x_y <= BASIS_ZERO;
            basis_reg.x_z <= BASIS_ZERO;
            basis_reg.y_x <= BASIS_ZERO;
            basis_reg.y_y <= BASIS_ONE;
            basis_reg.y_z <= BASIS_ZERO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASIS_X_X: basis_reg.x_x <= cfg_data;
                CFG_BASIS_X_Y: basis_reg.x_y <= cfg_data;
                CFG_BASIS_X_Z: basis_reg.x_z <= cfg_data;
                CFG_BASIS_Y_X: basis_reg.y_x <= cfg_data;
                CFG_BASIS_Y_Y: basis_reg.y_y <= cfg_data;
                CFG_BASIS_Y_Z: basis_reg.y_z <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control between the three register stages
    assign out_free       = !out_valid_reg || !vertex_stall;
    assign issue          = s2_valid_reg && out_free;
    assign s2_free        = !s2_valid_reg || (issue && corner_reg == CORNER_PM);
    assign move           = s1_valid_reg && s2_free;
    assign particle_stall = s1_valid_reg && !s2_free;
    assign accept         = particle_valid && !particle_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s2_free);
    assign s2_valid_next  = move || (s2_valid_reg && !s2_free);
    assign out_valid_next = issue || (out_valid_reg && vertex_stall);

    // Corner counter restarts with each new particle in the working stage
    always_comb
    begin
        if (move)
            corner_next = CORNER_PP;
        else if (issue)
            corner_next = corner_reg + 2'd1;
        else
            corner_next = corner_reg;
    end

    bqe_scale u_scale (
        .basis     (basis_reg),
        .half_size (s1_reg.half_size),
        .scaled    (scaled_next)
    );

    bqe_vertex u_vertex (
        .particle (s2_reg),
        .scaled   (scaled_reg),
        .corner   (corner_reg),
        .vertex   (vertex_next)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            corner_reg    <= CORNER_PP;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            corner_reg    <= corner_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= particle;
        if (move)
        begin
            s2_reg     <= s1_reg;
            scaled_reg <= scaled_next;
        end
        if (issue)
            out_reg <= vertex_next;
    end

    assign vertex_valid = out_valid_reg;
    assign vertex       = out_reg;

endmodule

FILE: tb/billboard_quad_expander_tb.sv
// Self-checking testbench for the billboard quad expander: particles, bases, back-pressure.
module billboard_quad_expander_tb;
    import bqe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes beyond the basis set, writes to these are dropped
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam int LONG_HOLD = 300;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        particle_valid = 1'b0;
    logic        particle_stall;
    particle_t   particle       = '0;
    logic        vertex_valid;
    logic        vertex_stall   = 1'b0;
    vertex_t     vertex;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index      = '0;
    logic [15:0] cfg_data       = '0;

    // Particles waiting to be offered, and vertices still owed by the block
    particle_t particle_backlog[$];
    vertex_t   awaited_vertices[$];

    // Camera bases as this bench believes them to be
    basis_t cam_basis;

    bit particle_taken = 1'b0;
    bit bursts_on      = 1'b0;
    bit sender_paused  = 1'b0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int long_hold_left = 0;
    int long_hold_req  = 0;
    int long_hold_done = 0;

    int errors         = 0;
    int particles_in   = 0;
    int vertices_out   = 0;
    int held_off_beats = 0;
    int settings_used  = 0;

    billboard_quad_expander dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .particle_valid (particle_valid),
        .particle_stall (particle_stall),
        .particle       (particle),
        .vertex_valid   (vertex_valid),
        .vertex_stall   (vertex_stall),
        .vertex         (vertex),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // Q1.15 basis times Q12.12 size, floored down to Q.12
    function automatic longint scaled_axis(logic signed [15:0] b, logic [23:0] s);
        longint prod;
        prod = longint'(b) * longint'({8'd0, s});
        return prod >>> 15;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Four corner vertices of one particle, in emission order
    task automatic expand_quad(particle_t p);
        longint rx, ry, rz, ux, uy, uz, rs, us;
        vertex_t v;
        logic [1:0] corner_order[4];
        corner_order = '{CORNER_PP, CORNER_MP, CORNER_MM, CORNER_PM};
        rx = scaled_axis(cam_basis.x_x, p.half_size);
        ry = scaled_axis(cam_basis.x_y, p.half_size);
        rz = scaled_axis(cam_basis.x_z, p.half_size);
        ux = scaled_axis(cam_basis.y_x, p.half_size);
        uy = scaled_axis(cam_basis.y_y, p.half_size);
        uz = scaled_axis(cam_basis.y_z, p.half_size);
        for (int k = 0; k < 4; k++)
        begin
            rs = (corner_order[k] == CORNER_PP || corner_order[k] == CORNER_PM) ? 1 : -1;
            us = (corner_order[k] == CORNER_PP || corner_order[k] == CORNER_MP) ? 1 : -1;
            v.vert_x     = clamp32(longint'(p.pos_x) + rs * rx + us * ux);
            v.vert_y     = clamp32(longint'(p.pos_y) + rs * ry + us * uy);
            v.vert_z     = clamp32(longint'(p.pos_z) + rs * rz + us * uz);
            v.colour_out = p.colour_in;
            v.tex_u      = (rs > 0) ? p.u_end : p.u_start;
            v.tex_v      = (us > 0) ? p.v_end : p.v_start;
            v.corner     = corner_order[k];
            v.last       = (corner_order[k] == CORNER_PM);
            awaited_vertices.push_back(v);
        end
    endtask

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: vertex %s mismatch, expected %h, got %h",
                     $time, field, want, got);
            errors++;
        end
    endtask

    // Acceptance on both channels, prediction and checking
    always @(posedge clk)
    begin
        vertex_t want;
        particle_taken <= particle_valid && !particle_stall;
        if (particle_valid && particle_stall && long_hold_left > 0)
            held_off_beats++;
        if (particle_valid && !particle_stall)
        begin
            expand_quad(particle);
            particles_in++;
        end
        if (vertex_valid && !vertex_stall)
        begin
            vertices_out++;
            if (awaited_vertices.size() == 0)
            begin
                $display("%0t ns: unexpected vertex, expected none, got %h", $time, vertex);
                errors++;
            end
            else
            begin
                want = awaited_vertices.pop_front();
                compare_field("vert_x", want.vert_x, vertex.vert_x);
                compare_field("vert_y", want.vert_y, vertex.vert_y);
                compare_field("vert_z", want.vert_z, vertex.vert_z);
                compare_field("colour_out", want.colour_out, vertex.colour_out);
                compare_field("tex_u", 32'(want.tex_u), 32'(vertex.tex_u));
                compare_field("tex_v", 32'(want.tex_v), 32'(vertex.tex_v));
                compare_field("corner", 32'(want.corner), 32'(vertex.corner));
                compare_field("last", 32'(want.last), 32'(vertex.last));
            end
        end
    end

    // Particle driver, with random gap bursts
    always @(negedge clk)
    begin
        if (!particle_valid || particle_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap       <= send_gap - 1;
                particle_valid <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 7) == 0)
            begin
                send_gap       <= $urandom_range(0, 14);
                particle_valid <= 1'b0;
            end
            else if (!sender_paused && particle_backlog.size() > 0)
            begin
                particle       <= particle_backlog.pop_front();
                particle_valid <= 1'b1;
            end
            else
                particle_valid <= 1'b0;
        end
    end

    // Vertex receiver: long hold when asked, otherwise random stall bursts
    always @(negedge clk)
    begin
        if (long_hold_left > 0)
        begin
            long_hold_left <= long_hold_left - 1;
            vertex_stall   <= 1'b1;
        end
        else if (long_hold_req != long_hold_done)
        begin
            long_hold_done <= long_hold_req;
            long_hold_left <= LONG_HOLD - 1;
            vertex_stall   <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap     <= recv_gap - 1;
            vertex_stall <= 1'b1;
        end
        else if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            recv_gap     <= $urandom_range(0, 14);
            vertex_stall <= 1'b1;
        end
        else
            vertex_stall <= 1'b0;
    end

    task automatic reg_write(logic [2:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BASIS_X_X: cam_basis.x_x = data;
            CFG_BASIS_X_Y: cam_basis.x_y = data;
            CFG_BASIS_X_Z: cam_basis.x_z = data;
            CFG_BASIS_Y_X: cam_basis.y_x = data;
            CFG_BASIS_Y_Y: cam_basis.y_y = data;
            CFG_BASIS_Y_Z: cam_basis.y_z = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_basis(basis_t b);
        reg_write(CFG_BASIS_X_X, b.x_x);
        reg_write(CFG_BASIS_X_Y, b.x_y);
        reg_write(CFG_BASIS_X_Z, b.x_z);
        reg_write(CFG_BASIS_Y_X, b.y_x);
        reg_write(CFG_BASIS_Y_Y, b.y_y);
        reg_write(CFG_BASIS_Y_Z, b.y_z);
        settings_used++;
    endtask

    // Wait until every particle is in and every vertex out, then let the pipe settle
    task automatic drain(int settle);
        do
            @(posedge clk);
        while (particle_backlog.size() != 0 || particle_valid || awaited_vertices.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    function automatic particle_t make_particle(logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz,
                                                logic [23:0] sz, logic [31:0] col,
                                                logic [15:0] u0, logic [15:0] v0,
                                                logic [15:0] u1, logic [15:0] v1);
        particle_t p;
        p.pos_x     = px;
        p.pos_y     = py;
        p.pos_z     = pz;
        p.half_size = sz;
        p.colour_in = col;
        p.u_start   = u0;
        p.v_start   = v0;
        p.u_end     = u1;
        p.v_end     = v1;
        return p;
    endfunction

    // Mostly modest positions and sizes, some full-range ones to hit saturation
    function automatic particle_t random_particle(bit modest_size);
        particle_t p;
        p = make_particle($urandom, $urandom, $urandom, 24'($urandom), $urandom,
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) != 0)
        begin
            p.pos_x = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            p.pos_y = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            p.pos_z = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        end
        if (modest_size || $urandom_range(0, 2) != 0)
            p.half_size = 24'($urandom_range(0, 24'h00_FFFF));
        return p;
    endfunction

    task automatic queue_random(int count, bit modest_size);
        repeat (count) particle_backlog.push_back(random_particle(modest_size));
    endtask

    function automatic basis_t random_basis();
        basis_t b;
        b = {$urandom, $urandom, $urandom};
        return b;
    endfunction

    // Main sequence of phases
    initial
    begin
        cam_basis = '{x_x: BASIS_ONE, x_y: BASIS_ZERO, x_z: BASIS_ZERO,
                      y_x: BASIS_ZERO, y_y: BASIS_ONE, y_z: BASIS_ZERO};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        settings_used = 1;

        // Identity bases after reset: extremes of every field
        particle_backlog.push_back(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        particle_backlog.push_back(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   24'hFF_FFFF, 32'hFFFF_FFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        particle_backlog.push_back(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   24'hFF_FFFF, 0, 0, 0, 0, 0));
        particle_backlog.push_back(make_particle(32'h0012_3000, 32'hFFF0_0000, 32'h0000_1000,
                                   0, 32'h1234_5678, 16'hFFFF, 16'hFFFF, 0, 0));
        particle_backlog.push_back(make_particle(0, 0, 0, 1, 32'h8000_0001,
                                   16'h0001, 16'h0002, 16'h8000, 16'h7FFF));
        particle_backlog.push_back(make_particle(32'h7FFF_F000, 32'h8000_0FFF, 0,
                                   24'h00_1000, 32'hDEAD_BEEF, 0, 16'hFFFF, 16'hFFFF, 0));
        particle_backlog.push_back(make_particle(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                   24'h55_5555, 32'hAAAA_AAAA,
                                   16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555));
        particle_backlog.push_back(make_particle(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                   24'hAA_AAAA, 32'h5555_5555,
                                   16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA));
        drain(6);

        // Most negative bases: the largest scaled magnitudes and floor rounding
        load_basis({6{16'sh8000}});
        particle_backlog.push_back(make_particle(0, 0, 0, 24'hFF_FFFF, 32'h0F0F_0F0F,
                                   16'h0100, 16'h0200, 16'h0300, 16'h0400));
        particle_backlog.push_back(make_particle(0, 0, 0, 1, 0, 0, 0, 0, 0));
        particle_backlog.push_back(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   24'hFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
        particle_backlog.push_back(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   24'hFF_FFFF, 0, 16'hFFFF, 0, 0, 16'hFFFF));
        bursts_on = 1'b1;
        queue_random(35, 1'b0);
        drain(6);

        // Most positive bases
        load_basis({6{16'sh7FFF}});
        queue_random(35, 1'b0);
        drain(6);

        // Spare indexes are ignored; bases of minus one round small sizes down
        load_basis({6{16'shFFFF}});
        reg_write(CFG_SPARE_6, 16'h1234);
        reg_write(CFG_SPARE_7, 16'hFFFF);
        particle_backlog.push_back(make_particle(0, 0, 0, 1, 32'hCAFE_F00D, 1, 2, 3, 4));
        particle_backlog.push_back(make_particle(32'h1000, 32'h1000, 32'h1000, 24'h00_7FFF,
                                   0, 5, 6, 7, 8));
        queue_random(30, 1'b1);
        drain(6);

        // Random bases, receiver holds off long enough to back up the input
        load_basis(random_basis());
        queue_random(60, 1'b0);
        @(posedge clk);
        long_hold_req++;
        drain(6);

        // Random bases, sender stops until every owed vertex has arrived
        load_basis(random_basis());
        queue_random(60, 1'b0);
        do
            @(posedge clk);
        while (particle_backlog.size() > 30);
        sender_paused = 1'b1;
        do
            @(posedge clk);
        while (particle_valid || awaited_vertices.size() != 0);
        repeat (5) @(posedge clk);
        sender_paused = 1'b0;
        drain(6);

        // Random bases again, then a final stretch at full rate
        load_basis(random_basis());
        queue_random(30, 1'b0);
        drain(6);
        bursts_on = 1'b0;
        queue_random(30, 1'b0);
        drain(20);

        $display("Ran %0d particles into %0d vertices across %0d basis settings.",
                 particles_in, vertices_out, settings_used);
        $display("Input was held off for %0d beats during the long receiver stall.",
                 held_off_beats);
        if (errors == 0 && awaited_vertices.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d vertices still owed.", awaited_vertices.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
